### rtl/core/bpq_pkg.sv
// Shared constants, codes and controller command type for the bounded priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRI_W    = 16;
  localparam int PL_W     = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MAX_W    = 5;
  localparam int CMP_W    = (CNT_W > MAX_W) ? CNT_W : MAX_W;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 3;

  localparam int IN_DATA_W    = ((PRI_W + PL_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PRI_W + PL_W + OCC_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(16);

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } bpq_cmd_t;

endpackage

### rtl/core/bpq_ctrl.sv
// Controller for the priority queue: request capture, execute step and output word valid.
`timescale 1ns / 1ps

module bpq_ctrl import bpq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output bpq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = out_valid_r;
  assign cmd.capture = in_tvalid && (state_r == S_IDLE);
  // The step runs once the output register is free or is being emptied this cycle.
  assign cmd.exec    = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/bpq_datapath.sv
// Datapath for the priority queue: sorted cell array with parallel compare-and-shift.
`timescale 1ns / 1ps

module bpq_datapath import bpq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bpq_cmd_t            cmd,
  input  logic                req_op,
  input  logic [PRI_W-1:0]    req_pri,
  input  logic [PL_W-1:0]     req_pl,
  input  logic                cfg_wr_en,
  input  logic [MAX_W-1:0]    cfg_wr_data,
  output logic [STATUS_W-1:0] res_status,
  output logic [PRI_W-1:0]    res_pri,
  output logic [PL_W-1:0]     res_pl,
  output logic [OCC_W-1:0]    res_occ
);

  logic [PRI_W-1:0]    op_pri_r;
  logic [PL_W-1:0]     op_pl_r;
  op_t                 op_r;

  logic [PRI_W-1:0]    cell_pri_r [CAPACITY];
  logic [PL_W-1:0]     cell_pl_r  [CAPACITY];
  logic [PRI_W-1:0]    cell_pri_nxt [CAPACITY];
  logic [PL_W-1:0]     cell_pl_nxt  [CAPACITY];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MAX_W-1:0]    max_r;

  logic [STATUS_W-1:0] status_r;
  logic [PRI_W-1:0]    res_pri_r;
  logic [PL_W-1:0]     res_pl_r;

  logic [CMP_W-1:0]    max_ext;
  logic [CMP_W-1:0]    lim_ext;
  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    count_m1;
  logic [CNT_W-1:0]    eff_count;
  logic                full;
  logic                empty;
  logic                beats_last;
  logic [CAPACITY-1:0] ge;
  status_t             status_nxt;
  logic [PRI_W-1:0]    res_pri_nxt;
  logic [PL_W-1:0]     res_pl_nxt;

  // Effective limit: zero acts as one, anything above the array size acts as the size.
  always_comb begin
    max_ext = CMP_W'(max_r);
    if (max_ext == '0) begin
      lim_ext = CMP_W'(1);
    end else if (max_ext > CMP_W'(CAPACITY)) begin
      lim_ext = CMP_W'(CAPACITY);
    end else begin
      lim_ext = max_ext;
    end
    lim = CNT_W'(lim_ext);
  end

  assign count_m1   = count_r - CNT_W'(1);
  assign full       = (count_r >= lim);
  assign empty      = (count_r == '0);
  assign beats_last = $signed(op_pri_r) > $signed(cell_pri_r[count_m1[IDX_W-1:0]]);
  // On eviction the lowest entry is dropped first, so the search ignores it.
  assign eff_count  = (full && !empty) ? count_m1 : count_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < eff_count) && ($signed(cell_pri_r[i]) >= $signed(op_pri_r));
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_pri_nxt[i] = cell_pri_r[i];
      cell_pl_nxt[i]  = cell_pl_r[i];
    end
    count_nxt   = count_r;
    res_pri_nxt = '0;
    res_pl_nxt  = '0;
    status_nxt  = ST_DROPPED;
    unique case (op_r)
      OP_EXTRACT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt  = ST_POPPED;
          res_pri_nxt = cell_pri_r[0];
          res_pl_nxt  = cell_pl_r[0];
          count_nxt   = count_m1;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_pri_nxt[i] = cell_pri_r[i+1];
            cell_pl_nxt[i]  = cell_pl_r[i+1];
          end
        end
      end
      OP_INSERT: begin
        if (!full || beats_last) begin
          if (!full) begin
            status_nxt = ST_INSERTED;
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            status_nxt = ST_EVICTED;
          end
          // Each cell keeps its entry, takes the new one, or takes its upper neighbor.
          if (!ge[0]) begin
            cell_pri_nxt[0] = op_pri_r;
            cell_pl_nxt[0]  = op_pl_r;
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (!ge[i]) begin
              if (ge[i-1]) begin
                cell_pri_nxt[i] = op_pri_r;
                cell_pl_nxt[i]  = op_pl_r;
              end else begin
                cell_pri_nxt[i] = cell_pri_r[i-1];
                cell_pl_nxt[i]  = cell_pl_r[i-1];
              end
            end
          end
        end
      end
      default: status_nxt = ST_DROPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(req_op);
      op_pri_r <= req_pri;
      op_pl_r  <= req_pl;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_pri_r[i] <= cell_pri_nxt[i];
        cell_pl_r[i]  <= cell_pl_nxt[i];
      end
      status_r  <= status_nxt;
      res_pri_r <= res_pri_nxt;
      res_pl_r  <= res_pl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= MAX_RESET;
    end else if (cfg_wr_en) begin
      count_r <= '0;
      max_r   <= cfg_wr_data;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Occupancy is reported from the count held after the step.
  logic [CNT_W-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      occ_r <= count_nxt;
    end
  end

  assign res_status = status_r;
  assign res_pri    = res_pri_r;
  assign res_pl     = res_pl_r;
  assign res_occ    = OCC_W'(occ_r);

endmodule

### rtl/core/bounded_priority_queue_unit.sv
// Top level of the bounded sorted priority queue.
// The input word is registered first; the execute step then writes the result word, and a held result stalls it.
// Each word takes a capture step, then an execute step; a new word is taken only after the last one has executed.
// The cell array inserts or pops in a single execute step through parallel compares in every cell.
// Reset (rst_n low, synchronous) empties the queue, sets the limit to 16 and drops the output.
// A configuration write sets the limit and empties the queue.
`timescale 1ns / 1ps

module bounded_priority_queue_unit import bpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // priority_req, payload
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_priority, out_payload, occupancy, zero pad
  output logic [STATUS_W-1:0]   out_tuser,  // status
  input  logic                  cfg_wr_en,
  input  logic [MAX_W-1:0]      cfg_wr_data
);

  bpq_cmd_t         cmd;
  logic [PRI_W-1:0] res_pri;
  logic [PL_W-1:0]  res_pl;
  logic [OCC_W-1:0] res_occ;

  bpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bpq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_op      (in_tuser),
    .req_pri     (in_tdata[PRI_W-1:0]),
    .req_pl      (in_tdata[PRI_W+PL_W-1:PRI_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_status  (out_tuser),
    .res_pri     (res_pri),
    .res_pl      (res_pl),
    .res_occ     (res_occ)
  );

  assign out_tdata = OUT_DATA_W'({res_occ, res_pl, res_pri});

endmodule

### rtl/core/bpq_checker.sv
// Port-level assertions for the priority queue, bound to the top level.
`timescale 1ns / 1ps

module bpq_checker import bpq_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // No result word survives a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= STATUS_W'(ST_EMPTY)))
    else $error("status code out of range");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PRI_W+PL_W+OCC_W-1:PRI_W+PL_W] <= OCC_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // Only a pop carries an entry; every other status shows zeros.
  a_zero_unless_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STATUS_W'(ST_POPPED))) |->
      (out_tdata[PRI_W+PL_W-1:0] == '0))
    else $error("entry fields nonzero without a pop");

  // One word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while one is in progress");

endmodule

bind bounded_priority_queue_unit bpq_checker u_bpq_checker (.*);

### sim/bpq_order_checker.sv
// Checker for the bounded priority queue: predicts each result word and compares it.
`timescale 1ns / 1ps

module bpq_order_checker import bpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]   out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [MAX_W-1:0]      cfg_wr_data,
  output int                    fail_count,
  output int                    pending_words
);

  typedef struct packed {
    status_t           status;
    logic [PRI_W-1:0]  pri;
    logic [PL_W-1:0]   pl;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  // Predicted queue contents, highest priority in slot 0.
  logic signed [PRI_W-1:0] slot_pri [CAPACITY];
  logic [PL_W-1:0]         slot_pl  [CAPACITY];
  int                      held;
  logic [MAX_W-1:0]        limit_reg;
  queue_result_t           awaited_results [$];
  int                      mismatches;

  // Goes behind every entry of equal or higher priority, so ties leave in arrival order.
  task automatic place_entry(input logic signed [PRI_W-1:0] pr, input logic [PL_W-1:0] pv);
    int pos;
    int i;
    pos = 0;
    while (pos < held && slot_pri[pos] >= pr) pos++;
    for (i = held; i > pos; i--) begin
      slot_pri[i] = slot_pri[i-1];
      slot_pl[i]  = slot_pl[i-1];
    end
    slot_pri[pos] = pr;
    slot_pl[pos]  = pv;
    held++;
  endtask

  task automatic apply_queue_op(input op_t op, input logic signed [PRI_W-1:0] pr,
                                input logic [PL_W-1:0] pv, output queue_result_t r);
    int cap;
    int i;
    cap = (limit_reg == 0) ? 1 : (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
    r.pri = '0;
    r.pl  = '0;
    if (op == OP_EXTRACT) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.pri = slot_pri[0];
        r.pl  = slot_pl[0];
        for (i = 1; i < held; i++) begin
          slot_pri[i-1] = slot_pri[i];
          slot_pl[i-1]  = slot_pl[i];
        end
        held--;
        r.status = ST_POPPED;
      end
    end else if (held < cap) begin
      place_entry(pr, pv);
      r.status = ST_INSERTED;
    end else if (pr > slot_pri[held-1]) begin
      held--;
      place_entry(pr, pv);
      r.status = ST_EVICTED;
    end else begin
      r.status = ST_DROPPED;
    end
    r.occ = OCC_W'(held);
  endtask

  always @(posedge clk) begin
    queue_result_t predicted;
    queue_result_t want;
    logic [PRI_W-1:0] got_pri;
    logic [PL_W-1:0]  got_pl;
    logic [OCC_W-1:0] got_occ;
    if (!rst_n) begin
      held       = 0;
      limit_reg  = MAX_RESET;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      // A limit write also empties the queue.
      if (cfg_wr_en) begin
        limit_reg = cfg_wr_data;
        held      = 0;
      end
      if (in_tvalid && in_tready) begin
        apply_queue_op(op_t'(in_tuser), in_tdata[PRI_W-1:0], in_tdata[PRI_W +: PL_W],
                       predicted);
        awaited_results.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        got_pri = out_tdata[PRI_W-1:0];
        got_pl  = out_tdata[PRI_W +: PL_W];
        got_occ = out_tdata[PRI_W+PL_W +: OCC_W];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected: status %0d occupancy %0d",
                     $realtime, out_tuser, got_occ);
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.status || got_pri !== want.pri || got_pl !== want.pl ||
              got_occ !== want.occ) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch status %0d/%0d priority %0d/%0d payload %0h/%0h occ %0d/%0d",
                       $realtime, want.status, out_tuser, $signed(want.pri), $signed(got_pri),
                       want.pl, got_pl, want.occ, got_occ);
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_words <= awaited_results.size();
  end

endmodule

### sim/bounded_priority_queue_unit_tb.sv
// Testbench top for the bounded priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bounded_priority_queue_unit_tb;
  import bpq_pkg::*;

  localparam logic signed [PRI_W-1:0] PRI_MAX = 16'sh7FFF;
  localparam logic signed [PRI_W-1:0] PRI_MIN = 16'sh8000;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 85;
  localparam int CYCLE_LIMIT     = 300000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [MAX_W-1:0]      cfg_wr_data = '0;
  int                    fail_count;
  int                    pending_words;

  int burst_left = 0;
  int rx_left    = 0;
  int cycles     = 0;
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;

  // Limits 0, 17 and 31 check the clamping; insert bias varies so the queue both fills and drains.
  int phase_limit [PHASES] = '{31, 1, 0, 16, 5, 16, 2, 9, 17, 3};
  int phase_bias  [PHASES] = '{75, 50, 40, 80, 60, 55, 45, 70, 85, 35};

  always #10 clk = ~clk;

  bounded_priority_queue_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bpq_order_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Receiver alternates ready and stall runs of random length, or stays ready in steady phases.
  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_steady || !out_tready) begin
      out_tready <= 1'b1;
      rx_left    <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b0;
      rx_left    <= $urandom_range(0, 9);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_priority_queue_unit_tb failed");
      $finish;
    end
  end

  // Valid stays high across a burst; it is only lowered when a real gap follows.
  task automatic send_word(input op_t op, input logic signed [PRI_W-1:0] pr,
                           input logic [PL_W-1:0] pv);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pv, pr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!tx_steady) begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_limit(input logic [MAX_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Narrow priorities make ties and equal-to-lowest drops common.
  function automatic logic signed [PRI_W-1:0] pick_priority();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      case ($urandom_range(0, 3))
        0: return PRI_MAX;
        1: return PRI_MIN;
        2: return '0;
        default: return '1;
      endcase
    end else if (mode <= 5) begin
      return PRI_W'($signed($urandom_range(0, 16)) - 8);
    end
    return PRI_W'($urandom);
  endfunction

  task automatic send_random(input int insert_pct);
    logic [PL_W-1:0] pv;
    pv = ($urandom_range(0, 9) == 0) ? {PL_W{$urandom_range(0, 1) == 1}} : PL_W'($urandom);
    if ($urandom_range(0, 99) < insert_pct)
      send_word(OP_INSERT, pick_priority(), pv);
    else
      send_word(OP_EXTRACT, PRI_W'($urandom), pv);
  endtask

  initial begin
    int ph;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: extract from empty, extremes, a tie and a drain past empty.
    send_word(OP_EXTRACT, '0, '0);
    send_word(OP_INSERT, PRI_MAX, 16'hFFFF);
    send_word(OP_INSERT, PRI_MIN, 16'h0000);
    send_word(OP_INSERT, 16'sd100, 16'h0001);
    send_word(OP_INSERT, 16'sd100, 16'h0002);
    send_word(OP_INSERT, -16'sd1, 16'h0003);
    repeat (6) send_word(OP_EXTRACT, PRI_W'($urandom), PL_W'($urandom));

    // Full queue: equal and lower priorities are dropped, a higher one evicts.
    set_limit(5'd2);
    send_word(OP_INSERT, 16'sd10, 16'h00A0);
    send_word(OP_INSERT, 16'sd10, 16'h00B0);
    send_word(OP_INSERT, 16'sd10, 16'h00C0);
    send_word(OP_INSERT, 16'sd9, 16'h00D0);
    send_word(OP_INSERT, 16'sd11, 16'h00E0);
    send_word(OP_INSERT, PRI_MIN, 16'h00F0);
    repeat (3) send_word(OP_EXTRACT, '0, '0);

    // A limit of zero behaves as one.
    set_limit(5'd0);
    send_word(OP_INSERT, 16'sd7, 16'h1234);
    send_word(OP_INSERT, 16'sd7, 16'h5678);
    send_word(OP_INSERT, 16'sd8, 16'h9ABC);
    send_word(OP_EXTRACT, '0, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      set_limit(MAX_W'(phase_limit[ph]));
      tx_steady  = (ph % 4 == 3);
      rx_steady  = (ph % 4 == 2) || (ph % 4 == 3);
      burst_left = 0;
      for (n = 0; n < WORDS_PER_PHASE; n++) send_random(phase_bias[ph]);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_priority_queue_unit_tb passed");
    end else begin
      $display("bounded_priority_queue_unit_tb failed");
    end
    $finish;
  end

endmodule
